[hdl/assert_macros.svh]
// Assertion macros shared by the tokenizer RTL.
// Every macro expects a clock named clk and an active-high reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define JST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define JST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hdl/jst_pkg.sv]
// Shared types, constants and helper functions of the JSON stream tokenizer.
// No dependencies.
package jst_pkg;

  localparam int MaxDepth = 64;
  localparam int DepthW   = $clog2(MaxDepth + 1);
  localparam int AddrW    = $clog2(MaxDepth);
  localparam int CntW     = 24;
  localparam int CpW      = 21;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_OBJ_OPEN  = 4'd1,
    EV_OBJ_CLOSE = 4'd2,
    EV_ARR_OPEN  = 4'd3,
    EV_ARR_CLOSE = 4'd4,
    EV_STR_CHAR  = 4'd5,
    EV_STR_END   = 4'd6,
    EV_KEY_END   = 4'd7,
    EV_TRUE      = 4'd8,
    EV_FALSE     = 4'd9,
    EV_NULL      = 4'd10,
    EV_NUM_CHAR  = 4'd11,
    EV_NUM_END   = 4'd12
  } ev_t;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_DONE    = 2'd1,
    ST_ERROR   = 2'd2,
    ST_AFTER   = 2'd3
  } status_t;

  localparam logic CMD_CHAR   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    ev_t             ev;
    logic            num_real;
    logic            key;
    logic [CpW-1:0]  cp;
  } event_t;

  typedef struct packed {
    logic            two;
    event_t          e0;
    event_t          e1;
    status_t         status;
    logic [CntW-1:0] line;
    logic [CntW-1:0] col;
  } core_res_t;

  typedef struct packed {
    event_t          e;
    status_t         status;
    logic [CntW-1:0] line;
    logic [CntW-1:0] col;
    logic            last;
  } out_rec_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // Returns {valid, nibble} for a hexadecimal digit.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") r = {1'b1, b[3:0]};
    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

endpackage

[hdl/jst_if.sv]
// Stream channel interfaces of the tokenizer: input bytes and result events.
// No dependencies.
interface jst_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_byte;
  modport source (output valid, cmd, char_byte, input ready);
  modport sink (input valid, cmd, char_byte, output ready);
endinterface

interface jst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic        number_is_real;
  logic        in_key;
  logic [20:0] code_point;
  logic [1:0]  status;
  logic [23:0] line_number;
  logic [23:0] column_number;
  logic        last_of_run;
  modport source (output valid, event_res, number_is_real, in_key, code_point, status,
                  line_number, column_number, last_of_run, input ready);
  modport sink (input valid, event_res, number_is_real, in_key, code_point, status,
                line_number, column_number, last_of_run, output ready);
endinterface

[hdl/json_stream_tokenizer_top.sv]
// Top level of the JSON stream tokenizer: input register, parser core, result queue.
// Depends on jst_pkg, jst_if.sv, jst_core and jst_queue.
//
//  port  | direction | carries
//  inp   | sink      | cmd, char_byte: one text byte or an end-of-input request
//  outp  | source    | one token event with status and line/column position
//
// A request is registered, then parsed combinationally and written to a 4-entry queue.
// Rate: one request per cycle while the queue has room; a request that yields two results
// hands them out one at a time through the single queue read port.
// Reset (rst, synchronous) empties the queue and returns the parser to wait for a value.
// An output stall holds requests once the queue has fewer than two free entries.
module json_stream_tokenizer_top import jst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  jst_in_if.sink    inp,
  jst_out_if.source outp
);

  logic       s1_valid;
  logic       s1_cmd;
  logic [7:0] s1_byte;
  logic       room;
  logic       go;
  core_res_t  res;

  assign go        = s1_valid && room;
  assign inp.ready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (inp.ready) begin
      s1_valid <= inp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (inp.ready && inp.valid) begin
      s1_cmd  <= inp.cmd;
      s1_byte <= inp.char_byte;
    end
  end

  jst_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .cmd       (s1_cmd),
    .char_byte (s1_byte),
    .res       (res)
  );

  jst_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_go (go),
    .res     (res),
    .room    (room),
    .outp    (outp)
  );

endmodule

[hdl/jst_core.sv]
// Parser state machine, container stack and position counters.
// Depends on jst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jst_core import jst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      go,
  input  logic      cmd,
  input  logic [7:0] char_byte,
  output core_res_t res
);

  typedef enum logic [30:0] {
    S_VALUE   = 31'd1 << 0,
    S_DONE    = 31'd1 << 1,
    S_KEY     = 31'd1 << 2,
    S_COLON   = 31'd1 << 3,
    S_COMMA   = 31'd1 << 4,
    S_T1      = 31'd1 << 5,
    S_T2      = 31'd1 << 6,
    S_T3      = 31'd1 << 7,
    S_F1      = 31'd1 << 8,
    S_F2      = 31'd1 << 9,
    S_F3      = 31'd1 << 10,
    S_F4      = 31'd1 << 11,
    S_N1      = 31'd1 << 12,
    S_N2      = 31'd1 << 13,
    S_N3      = 31'd1 << 14,
    S_STR     = 31'd1 << 15,
    S_ESC     = 31'd1 << 16,
    S_UHEX    = 31'd1 << 17,
    S_PB      = 31'd1 << 18,
    S_PU      = 31'd1 << 19,
    S_LHEX    = 31'd1 << 20,
    S_NUM     = 31'd1 << 21,
    S_SIGN    = 31'd1 << 22,
    S_ZERO    = 31'd1 << 23,
    S_DOT     = 31'd1 << 24,
    S_FRAC    = 31'd1 << 25,
    S_EXP     = 31'd1 << 26,
    S_EXPSIGN = 31'd1 << 27,
    S_EXPNUM  = 31'd1 << 28,
    S_ERR     = 31'd1 << 29,
    S_AFTER   = 31'd1 << 30
  } state_t;

  typedef struct packed {
    state_t st;
    logic   pop;
    logic   jo_clear;
    ev_t    ev;
  } punct_t;

  state_t            state, state_next;
  logic [DepthW-1:0] depth, depth_next;
  logic              just_opened, just_opened_next;
  logic [15:0]       hi_unit, hi_unit_next;
  logic [15:0]       lo_unit, lo_unit_next;
  logic [1:0]        hex_idx, hex_idx_next;
  logic              str_key, str_key_next;
  logic              top_kind, top_kind_next;
  logic              below_kind;
  logic [CntW-1:0]   line, line_next;
  logic [CntW-1:0]   col, col_next;
  logic              push, push_kind;
  logic              kinds [MaxDepth];
  logic [AddrW-1:0]  rd_addr;
  logic              top_obj;
  logic [4:0]        hv;
  logic [15:0]       unit_acc;
  punct_t            pr;
  state_t            mid_state;
  event_t            e0, e1;
  logic              two;

  localparam logic [CntW-1:0] CntMax = '1;

  // Handling of a byte after a complete value: separators, closers, trailing data.
  function automatic punct_t punct_step(input state_t s, input logic [7:0] b,
                                        input logic [DepthW-1:0] d, input logic tobj);
    punct_t p;
    logic   close;
    p.st       = s;
    p.pop      = 1'b0;
    p.jo_clear = 1'b0;
    p.ev       = EV_NONE;
    close      = 1'b0;
    if (s == S_DONE) begin
      if (!is_ws(b)) p.st = S_AFTER;
    end else if (!is_ws(b)) begin
      if (b == ",") begin
        p.jo_clear = 1'b1;
        p.st       = tobj ? S_KEY : S_VALUE;
      end else if (b == "}" && tobj) close = 1'b1;
      else if (b == "]" && d != '0 && !tobj) close = 1'b1;
      else p.st = S_ERR;
    end
    if (close) begin
      p.pop = 1'b1;
      p.ev  = tobj ? EV_OBJ_CLOSE : EV_ARR_CLOSE;
      p.st  = (d != DepthW'(1)) ? S_COMMA : S_DONE;
    end
    return p;
  endfunction

  assign top_obj  = depth != '0 && top_kind;
  assign hv       = hex_val(char_byte);
  assign unit_acc = {(state == S_UHEX) ? hi_unit[11:0] : lo_unit[11:0], hv[3:0]};
  assign pr       = punct_step(mid_state, char_byte, depth, top_obj);

  always_comb begin
    state_next       = state;
    depth_next       = depth;
    just_opened_next = just_opened;
    hi_unit_next     = hi_unit;
    lo_unit_next     = lo_unit;
    hex_idx_next     = hex_idx;
    str_key_next     = str_key;
    top_kind_next    = top_kind;
    line_next        = line;
    col_next         = col;
    push             = 1'b0;
    push_kind        = 1'b0;
    e0               = '{ev: EV_NONE, num_real: 1'b0, key: 1'b0, cp: '0};
    e1               = e0;
    two              = 1'b0;
    mid_state        = state;
    if (go) begin
      if (cmd == CMD_FINISH) begin
        if (state == S_NUM || state == S_ZERO || state == S_FRAC || state == S_EXPNUM) begin
          e0.ev       = EV_NUM_END;
          e0.num_real = state == S_FRAC || state == S_EXPNUM;
          state_next  = (depth != '0) ? S_COMMA : S_DONE;
        end
      end else begin
        if (char_byte == 8'h0A) begin
          if (line != CntMax) line_next = line + CntW'(1);
          col_next = '0;
        end else if (col != CntMax) begin
          col_next = col + CntW'(1);
        end
        unique case (state)
          S_DONE, S_COMMA: begin
            state_next = pr.st;
            e0.ev      = pr.ev;
            if (pr.jo_clear) just_opened_next = 1'b0;
          end
          S_VALUE: begin
            if (!is_ws(char_byte)) begin
              if (char_byte == "{" || char_byte == "[") begin
                if (depth >= DepthW'(MaxDepth)) state_next = S_ERR;
                else begin
                  push             = 1'b1;
                  push_kind        = char_byte == "{";
                  depth_next       = depth + DepthW'(1);
                  just_opened_next = 1'b1;
                  top_kind_next    = push_kind;
                  e0.ev            = push_kind ? EV_OBJ_OPEN : EV_ARR_OPEN;
                  state_next       = push_kind ? S_KEY : S_VALUE;
                end
              end else if (char_byte == "t") state_next = S_T1;
              else if (char_byte == "f") state_next = S_F1;
              else if (char_byte == "n") state_next = S_N1;
              else if (char_byte == "\"") begin
                str_key_next = 1'b0;
                state_next   = S_STR;
              end else if (char_byte == "-" || is_digit(char_byte)) begin
                e0.ev      = EV_NUM_CHAR;
                e0.cp      = CpW'(char_byte);
                state_next = (char_byte == "-") ? S_SIGN :
                             (char_byte == "0") ? S_ZERO : S_NUM;
              end else if (char_byte == "]" && depth != '0 && !top_kind && just_opened) begin
                e0.ev         = EV_ARR_CLOSE;
                depth_next    = depth - DepthW'(1);
                top_kind_next = below_kind;
                state_next    = (depth != DepthW'(1)) ? S_COMMA : S_DONE;
              end else state_next = S_ERR;
            end
          end
          S_KEY: begin
            if (!is_ws(char_byte)) begin
              if (char_byte == "\"") begin
                str_key_next = 1'b1;
                state_next   = S_STR;
              end else if (char_byte == "}" && just_opened && depth != '0) begin
                e0.ev         = top_kind ? EV_OBJ_CLOSE : EV_ARR_CLOSE;
                depth_next    = depth - DepthW'(1);
                top_kind_next = below_kind;
                state_next    = (depth != DepthW'(1)) ? S_COMMA : S_DONE;
              end else state_next = S_ERR;
            end
          end
          S_COLON: begin
            if (!is_ws(char_byte)) state_next = (char_byte == ":") ? S_VALUE : S_ERR;
          end
          S_T1: state_next = (char_byte == "r") ? S_T2 : S_ERR;
          S_T2: state_next = (char_byte == "u") ? S_T3 : S_ERR;
          S_F1: state_next = (char_byte == "a") ? S_F2 : S_ERR;
          S_F2: state_next = (char_byte == "l") ? S_F3 : S_ERR;
          S_F3: state_next = (char_byte == "s") ? S_F4 : S_ERR;
          S_N1: state_next = (char_byte == "u") ? S_N2 : S_ERR;
          S_N2: state_next = (char_byte == "l") ? S_N3 : S_ERR;
          S_T3, S_F4, S_N3: begin
            if ((state == S_T3 && char_byte == "e") || (state == S_F4 && char_byte == "e") ||
                (state == S_N3 && char_byte == "l")) begin
              e0.ev      = (state == S_T3) ? EV_TRUE : (state == S_F4) ? EV_FALSE : EV_NULL;
              state_next = (depth != '0) ? S_COMMA : S_DONE;
            end else state_next = S_ERR;
          end
          S_STR: begin
            if (char_byte == "\"") begin
              e0.ev      = str_key ? EV_KEY_END : EV_STR_END;
              e0.key     = str_key;
              state_next = str_key ? S_COLON : (depth != '0) ? S_COMMA : S_DONE;
            end else if (char_byte == "\\") state_next = S_ESC;
            else if (char_byte < 8'h20) state_next = S_ERR;
            else begin
              e0.ev  = EV_STR_CHAR;
              e0.key = str_key;
              e0.cp  = CpW'(char_byte);
            end
          end
          S_ESC: begin
            e0.ev      = EV_STR_CHAR;
            e0.key     = str_key;
            state_next = S_STR;
            case (char_byte)
              "\"":    e0.cp = CpW'(8'h22);
              "\\":    e0.cp = CpW'(8'h5C);
              "/":     e0.cp = CpW'(8'h2F);
              "b":     e0.cp = CpW'(8'h08);
              "f":     e0.cp = CpW'(8'h0C);
              "n":     e0.cp = CpW'(8'h0A);
              "r":     e0.cp = CpW'(8'h0D);
              "t":     e0.cp = CpW'(8'h09);
              "u": begin
                e0           = '{ev: EV_NONE, num_real: 1'b0, key: 1'b0, cp: '0};
                hi_unit_next = '0;
                hex_idx_next = '0;
                state_next   = S_UHEX;
              end
              default: begin
                e0         = '{ev: EV_NONE, num_real: 1'b0, key: 1'b0, cp: '0};
                state_next = S_ERR;
              end
            endcase
          end
          S_UHEX: begin
            if (!hv[4]) state_next = S_ERR;
            else begin
              hi_unit_next = unit_acc;
              hex_idx_next = hex_idx + 2'd1;
              if (hex_idx == 2'd3) begin
                if (unit_acc[15:10] == 6'b110110) state_next = S_PB;
                else begin
                  e0.ev      = EV_STR_CHAR;
                  e0.key     = str_key;
                  e0.cp      = CpW'(unit_acc);
                  state_next = S_STR;
                end
              end
            end
          end
          S_PB: state_next = (char_byte == "\\") ? S_PU : S_ERR;
          S_PU: begin
            if (char_byte == "u") begin
              lo_unit_next = '0;
              hex_idx_next = '0;
              state_next   = S_LHEX;
            end else state_next = S_ERR;
          end
          S_LHEX: begin
            if (!hv[4]) state_next = S_ERR;
            else begin
              lo_unit_next = unit_acc;
              hex_idx_next = hex_idx + 2'd1;
              if (hex_idx == 2'd3) begin
                if (unit_acc[15:10] == 6'b110111 && hi_unit[15:10] == 6'b110110) begin
                  // Pair to one code point: 0x10000 plus the two 10-bit payloads.
                  e0.ev      = EV_STR_CHAR;
                  e0.key     = str_key;
                  e0.cp      = CpW'(21'h10000) + CpW'({hi_unit[9:0], unit_acc[9:0]});
                  state_next = S_STR;
                end else state_next = S_ERR;
              end
            end
          end
          S_SIGN, S_DOT, S_EXPSIGN: begin
            if (is_digit(char_byte)) begin
              e0.ev      = EV_NUM_CHAR;
              e0.cp      = CpW'(char_byte);
              state_next = (state == S_SIGN) ? ((char_byte == "0") ? S_ZERO : S_NUM) :
                           (state == S_DOT) ? S_FRAC : S_EXPNUM;
            end else state_next = S_ERR;
          end
          S_EXP: begin
            if (is_digit(char_byte) || char_byte == "-" || char_byte == "+") begin
              e0.ev      = EV_NUM_CHAR;
              e0.cp      = CpW'(char_byte);
              state_next = is_digit(char_byte) ? S_EXPNUM : S_EXPSIGN;
            end else state_next = S_ERR;
          end
          S_NUM, S_ZERO, S_FRAC, S_EXPNUM: begin
            if ((state != S_ZERO && is_digit(char_byte)) ||
                (char_byte == "." && (state == S_NUM || state == S_ZERO)) ||
                ((char_byte == "e" || char_byte == "E") && state != S_EXPNUM)) begin
              e0.ev = EV_NUM_CHAR;
              e0.cp = CpW'(char_byte);
              if (char_byte == ".") state_next = S_DOT;
              else if (char_byte == "e" || char_byte == "E") state_next = S_EXP;
            end else begin
              // The byte ends the number and is then taken again as a separator.
              e0.ev            = EV_NUM_END;
              e0.num_real      = state == S_FRAC || state == S_EXPNUM;
              mid_state        = (depth != '0) ? S_COMMA : S_DONE;
              state_next       = pr.st;
              e1.ev            = pr.ev;
              two              = pr.ev != EV_NONE;
              if (pr.jo_clear) just_opened_next = 1'b0;
            end
          end
          S_ERR, S_AFTER: begin
          end
          default: state_next = S_ERR;
        endcase
        if ((state == S_DONE || state == S_COMMA || two) && pr.pop) begin
          depth_next    = depth - DepthW'(1);
          top_kind_next = below_kind;
        end
      end
    end
  end

  assign rd_addr = AddrW'(depth_next - DepthW'(2));

  always_ff @(posedge clk) begin
    if (push) kinds[depth[AddrW-1:0]] <= push_kind;
    below_kind <= kinds[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_VALUE;
      depth       <= '0;
      just_opened <= 1'b0;
      hi_unit     <= '0;
      lo_unit     <= '0;
      hex_idx     <= '0;
      str_key     <= 1'b0;
      top_kind    <= 1'b0;
      line        <= '0;
      col         <= '0;
    end else begin
      state       <= state_next;
      depth       <= depth_next;
      just_opened <= just_opened_next;
      hi_unit     <= hi_unit_next;
      lo_unit     <= lo_unit_next;
      hex_idx     <= hex_idx_next;
      str_key     <= str_key_next;
      top_kind    <= top_kind_next;
      line        <= line_next;
      col         <= col_next;
    end
  end

  always_comb begin
    res.two    = two;
    res.e0     = e0;
    res.e1     = e1;
    res.line   = line_next;
    res.col    = col_next;
    res.status = (state_next == S_DONE) ? ST_DONE :
                 (state_next == S_ERR) ? ST_ERROR :
                 (state_next == S_AFTER) ? ST_AFTER : ST_PENDING;
  end

  `JST_NEVER(a_depth_range, depth > DepthW'(MaxDepth), "nesting depth beyond stack size")
  `JST_ASSERT(a_err_sticky, (!$past(rst) && $past(state) == S_ERR) |-> state == S_ERR, "error state left")

endmodule

[hdl/jst_queue.sv]
// Result queue: splits each processed request into one or two result records.
// Depends on jst_pkg, jst_if.sv and assert_macros.svh.
`include "assert_macros.svh"
module jst_queue import jst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_go,
  input  core_res_t res,
  output logic      room,
  jst_out_if.source outp
);

  out_rec_t         q [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] cnt, cnt_next;
  logic             pop;
  out_rec_t         rec0, rec1, head;

  assign room = cnt <= QCntW'(QDepth - 2);
  assign pop  = outp.valid && outp.ready;
  assign head = q[rd_ptr];

  always_comb begin
    rec0 = '{e: res.e0, status: res.status, line: res.line, col: res.col, last: !res.two};
    rec1 = '{e: res.e1, status: res.status, line: res.line, col: res.col, last: 1'b1};
    cnt_next = cnt - QCntW'(pop);
    if (push_go) cnt_next = cnt_next + (res.two ? QCntW'(2) : QCntW'(1));
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      q[wr_ptr] <= rec0;
      if (res.two) q[wr_ptr + QPtrW'(1)] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      cnt <= cnt_next;
      if (pop) rd_ptr <= rd_ptr + QPtrW'(1);
      if (push_go) wr_ptr <= wr_ptr + (res.two ? QPtrW'(2) : QPtrW'(1));
    end
  end

  assign outp.valid          = cnt != '0;
  assign outp.event_res      = head.e.ev;
  assign outp.number_is_real = head.e.num_real;
  assign outp.in_key         = head.e.key;
  assign outp.code_point     = head.e.cp;
  assign outp.status         = head.status;
  assign outp.line_number    = head.line;
  assign outp.column_number  = head.col;
  assign outp.last_of_run    = head.last;

  `JST_NEVER(a_cnt_range, cnt > QCntW'(QDepth), "result queue count out of range")
  `JST_NEVER(a_no_overrun, push_go && !room, "request processed without queue room")

endmodule

[test/json_stream_tokenizer_top_tb.sv]
// Testbench of json_stream_tokenizer_top: streams JSON text, predicts every token event.
// Depends on jst_pkg, the channel interfaces in jst_if.sv and json_stream_tokenizer_top.
`timescale 1ns / 100ps

module json_stream_tokenizer_top_tb;
  import jst_pkg::*;

  typedef enum int {
    P_VALUE, P_DONE, P_KEY, P_COLON, P_COMMA, P_T1, P_T2, P_T3, P_F1, P_F2, P_F3, P_F4,
    P_N1, P_N2, P_N3, P_STR, P_ESC, P_U0, P_U1, P_U2, P_U3, P_PB, P_PU,
    P_L0, P_L1, P_L2, P_L3, P_NUM, P_SIGN, P_ZERO, P_DOT, P_FRAC, P_EXP, P_EXPSIGN,
    P_EXPNUM, P_ERR, P_AFTER
  } parse_t;

  logic clk;
  logic rst;
  jst_in_if  inp ();
  jst_out_if outp ();

  json_stream_tokenizer_top i_dut (.clk(clk), .rst(rst), .inp(inp), .outp(outp));

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Predictor state.
  parse_t          pst;
  bit              kinds [MaxDepth];
  int              depth;
  bit              just_opened;
  logic [15:0]     hi_unit;
  logic [15:0]     lo_unit;
  logic [CntW-1:0] line_cnt;
  logic [CntW-1:0] col_cnt;
  bit              str_key;
  int              ev_cnt;
  event_t          ev_buf [2];

  out_rec_t   expected_events [$];
  logic [7:0] text_q [$];
  int         errors;
  bit         busy_mode;
  bit         stall_mode;

  function automatic void note_event(ev_t c, int r, int k, int cp);
    if (ev_cnt < 2) begin
      ev_buf[ev_cnt] = '{ev: c, num_real: r[0], key: k[0], cp: cp[CpW-1:0]};
      ev_cnt++;
    end
  endfunction

  function automatic bit ws_char(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic bit digit_char(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  function automatic bit top_obj();
    return depth > 0 && kinds[depth-1];
  endfunction

  function automatic void value_done();
    pst = (depth != 0) ? P_COMMA : P_DONE;
  endfunction

  function automatic void open_cont(bit obj);
    if (depth >= MaxDepth) begin
      pst = P_ERR;
      return;
    end
    kinds[depth] = obj;
    depth++;
    just_opened = 1'b1;
    note_event(obj ? EV_OBJ_OPEN : EV_ARR_OPEN, 0, 0, 0);
    pst = obj ? P_KEY : P_VALUE;
  endfunction

  function automatic void close_cont();
    if (depth == 0) begin
      pst = P_ERR;
      return;
    end
    note_event(top_obj() ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 0, 0, 0);
    depth--;
    value_done();
  endfunction

  function automatic void num_end(bit r);
    note_event(EV_NUM_END, r, 0, 0);
    value_done();
  endfunction

  function automatic void lit_next(logic [7:0] b, logic [7:0] want, parse_t nxt);
    pst = (b == want) ? nxt : P_ERR;
  endfunction

  function automatic void lit_end(logic [7:0] b, logic [7:0] want, ev_t e);
    if (b == want) begin
      note_event(e, 0, 0, 0);
      value_done();
    end else begin
      pst = P_ERR;
    end
  endfunction

  // Returns 1 when the byte has to be parsed again in the new state.
  function automatic bit parse_byte(logic [7:0] b);
    int h;
    logic [20:0] c;
    parse_t s;
    s = pst;
    case (s)
      P_DONE: if (!ws_char(b)) pst = P_AFTER;
      P_VALUE: begin
        if (ws_char(b)) return 0;
        if (b == "{") open_cont(1);
        else if (b == "[") open_cont(0);
        else if (b == "t") pst = P_T1;
        else if (b == "f") pst = P_F1;
        else if (b == "n") pst = P_N1;
        else if (b == "\"") begin
          str_key = 0;
          pst = P_STR;
        end else if (b == "-") begin
          note_event(EV_NUM_CHAR, 0, 0, b);
          pst = P_SIGN;
        end else if (b == "0") begin
          note_event(EV_NUM_CHAR, 0, 0, b);
          pst = P_ZERO;
        end else if (digit_char(b)) begin
          note_event(EV_NUM_CHAR, 0, 0, b);
          pst = P_NUM;
        end else if (b == "]" && depth > 0 && !top_obj() && just_opened) close_cont();
        else pst = P_ERR;
      end
      P_KEY: begin
        if (ws_char(b)) return 0;
        if (b == "\"") begin
          str_key = 1;
          pst = P_STR;
        end else if (b == "}" && just_opened) close_cont();
        else pst = P_ERR;
      end
      P_COLON: begin
        if (ws_char(b)) return 0;
        pst = (b == ":") ? P_VALUE : P_ERR;
      end
      P_COMMA: begin
        if (ws_char(b)) return 0;
        if (b == ",") begin
          just_opened = 0;
          pst = top_obj() ? P_KEY : P_VALUE;
        end else if (b == "}" && top_obj()) close_cont();
        else if (b == "]" && depth > 0 && !top_obj()) close_cont();
        else pst = P_ERR;
      end
      P_T1: lit_next(b, "r", P_T2);
      P_T2: lit_next(b, "u", P_T3);
      P_T3: lit_end(b, "e", EV_TRUE);
      P_F1: lit_next(b, "a", P_F2);
      P_F2: lit_next(b, "l", P_F3);
      P_F3: lit_next(b, "s", P_F4);
      P_F4: lit_end(b, "e", EV_FALSE);
      P_N1: lit_next(b, "u", P_N2);
      P_N2: lit_next(b, "l", P_N3);
      P_N3: lit_end(b, "l", EV_NULL);
      P_STR: begin
        if (b == "\"") begin
          note_event(str_key ? EV_KEY_END : EV_STR_END, 0, str_key, 0);
          if (str_key) pst = P_COLON;
          else value_done();
        end else if (b == "\\") pst = P_ESC;
        else if (b < 8'h20) pst = P_ERR;
        else note_event(EV_STR_CHAR, 0, str_key, b);
      end
      P_ESC: begin
        c = 0;
        case (b)
          "\"": c = 21'h22;
          "\\": c = 21'h5C;
          "/": c = 21'h2F;
          "b": c = 21'h08;
          "f": c = 21'h0C;
          "n": c = 21'h0A;
          "r": c = 21'h0D;
          "t": c = 21'h09;
          "u": begin
            hi_unit = 0;
            pst = P_U0;
            return 0;
          end
          default: begin
            pst = P_ERR;
            return 0;
          end
        endcase
        note_event(EV_STR_CHAR, 0, str_key, c);
        pst = P_STR;
      end
      P_U0, P_U1, P_U2, P_U3: begin
        h = hex_digit(b);
        if (h < 0) begin
          pst = P_ERR;
          return 0;
        end
        hi_unit = {hi_unit[11:0], 4'(h)};
        if (s != P_U3) pst = parse_t'(s + 1);
        else if (hi_unit >= 16'hD800 && hi_unit < 16'hDC00) pst = P_PB;
        else begin
          note_event(EV_STR_CHAR, 0, str_key, hi_unit);
          pst = P_STR;
        end
      end
      P_PB: lit_next(b, "\\", P_PU);
      P_PU: begin
        if (b == "u") begin
          lo_unit = 0;
          pst = P_L0;
        end else pst = P_ERR;
      end
      P_L0, P_L1, P_L2, P_L3: begin
        h = hex_digit(b);
        if (h < 0) begin
          pst = P_ERR;
          return 0;
        end
        lo_unit = {lo_unit[11:0], 4'(h)};
        if (s != P_L3) pst = parse_t'(s + 1);
        else if (lo_unit >= 16'hDC00 && lo_unit <= 16'hDFFF &&
                 hi_unit >= 16'hD800 && hi_unit < 16'hDC00) begin
          note_event(EV_STR_CHAR, 0, str_key,
                     21'h10000 + ((21'(hi_unit) - 21'hD800) << 10) + (21'(lo_unit) - 21'hDC00));
          pst = P_STR;
        end else pst = P_ERR;
      end
      P_SIGN: begin
        if (b == "0") pst = P_ZERO;
        else if (digit_char(b)) pst = P_NUM;
        else begin
          pst = P_ERR;
          return 0;
        end
        note_event(EV_NUM_CHAR, 0, 0, b);
      end
      P_NUM, P_ZERO: begin
        if (s == P_NUM && digit_char(b)) ;
        else if (b == ".") pst = P_DOT;
        else if (b == "e" || b == "E") pst = P_EXP;
        else begin
          num_end(0);
          return 1;
        end
        note_event(EV_NUM_CHAR, 0, 0, b);
      end
      P_DOT: begin
        if (!digit_char(b)) begin
          pst = P_ERR;
          return 0;
        end
        pst = P_FRAC;
        note_event(EV_NUM_CHAR, 0, 0, b);
      end
      P_FRAC: begin
        if (b == "e" || b == "E") pst = P_EXP;
        else if (!digit_char(b)) begin
          num_end(1);
          return 1;
        end
        note_event(EV_NUM_CHAR, 0, 0, b);
      end
      P_EXP: begin
        if (b == "-" || b == "+") pst = P_EXPSIGN;
        else if (digit_char(b)) pst = P_EXPNUM;
        else begin
          pst = P_ERR;
          return 0;
        end
        note_event(EV_NUM_CHAR, 0, 0, b);
      end
      P_EXPSIGN: begin
        if (!digit_char(b)) begin
          pst = P_ERR;
          return 0;
        end
        pst = P_EXPNUM;
        note_event(EV_NUM_CHAR, 0, 0, b);
      end
      P_EXPNUM: begin
        if (!digit_char(b)) begin
          num_end(1);
          return 1;
        end
        note_event(EV_NUM_CHAR, 0, 0, b);
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic void predict_events(logic cmd, logic [7:0] b);
    status_t st;
    ev_cnt = 0;
    if (cmd == CMD_FINISH) begin
      if (pst == P_NUM || pst == P_ZERO) num_end(0);
      else if (pst == P_FRAC || pst == P_EXPNUM) num_end(1);
    end else begin
      if (b == 8'h0A) begin
        if (line_cnt != '1) line_cnt++;
        col_cnt = 0;
      end else if (col_cnt != '1) begin
        col_cnt++;
      end
      if (parse_byte(b)) void'(parse_byte(b));
    end
    st = pst == P_DONE ? ST_DONE : pst == P_ERR ? ST_ERROR :
         pst == P_AFTER ? ST_AFTER : ST_PENDING;
    if (ev_cnt == 0) note_event(EV_NONE, 0, 0, 0);
    for (int k = 0; k < ev_cnt; k++)
      expected_events.insert(expected_events.size(),
                             '{e: ev_buf[k], status: st, line: line_cnt, col: col_cnt,
                               last: (k + 1 == ev_cnt)});
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (busy_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(logic cmd, logic [7:0] b);
    int g;
    inp.valid = 1'b1;
    inp.cmd = cmd;
    inp.char_byte = b;
    do @(posedge clk); while (!inp.ready);
    predict_events(cmd, b);
    @(negedge clk);
    // With no gap, a following request raises valid again in the same time step.
    inp.valid = 1'b0;
    g = gap_len();
    repeat (g) @(negedge clk);
  endtask

  // Sends the queued text; a finish request may slip in before delimiters.
  task automatic send_text();
    logic [7:0] b;
    while (text_q.size() > 0) begin
      b = text_q.pop_front();
      if ((ws_char(b) || b == "," || b == "]" || b == "}") && $urandom_range(0, 19) == 0)
        send_request(CMD_FINISH, 8'h00);
      send_request(CMD_CHAR, b);
    end
  endtask

  function automatic void add_char(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void add_ws();
    int n;
    logic [7:0] w [4];
    w = '{8'h20, 8'h09, 8'h0A, 8'h0D};
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) add_char(w[$urandom_range(0, 3)]);
  endfunction

  function automatic void add_hex(logic [15:0] v);
    logic [7:0] ch;
    for (int i = 3; i >= 0; i--) begin
      ch = (v[i*4 +: 4] < 4'd10) ? "0" + v[i*4 +: 4] : "a" + v[i*4 +: 4] - 8'd10;
      if (ch >= "a" && $urandom_range(0, 1)) ch = ch - 8'h20;
      add_char(ch);
    end
  endfunction

  function automatic void gen_string();
    int n;
    logic [7:0] b;
    logic [7:0] esc [8];
    esc = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
    add_char("\"");
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: begin
          add_char("\\");
          add_char(esc[$urandom_range(0, 7)]);
        end
        1: begin
          add_str("\\u");
          if ($urandom_range(0, 1)) begin
            add_hex(16'($urandom_range(16'hD800, 16'hDBFF)));
            add_str("\\u");
            add_hex(16'($urandom_range(16'hDC00, 16'hDFFF)));
          end else begin
            b = 0;
            add_hex($urandom_range(0, 1) ? 16'($urandom_range(16'hDC00, 16'hFFFF))
                                         : 16'($urandom_range(0, 16'hD7FF)));
          end
        end
        default: begin
          do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == "\"" || b == "\\");
          add_char(b);
        end
      endcase
    end
    add_char("\"");
  endfunction

  function automatic void gen_digits(int lo);
    repeat ($urandom_range(lo, 3)) add_char(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void gen_number();
    if ($urandom_range(0, 2) == 0) add_char("-");
    if ($urandom_range(0, 3) == 0) add_char("0");
    else begin
      add_char(8'("1" + $urandom_range(0, 8)));
      gen_digits(0);
    end
    if ($urandom_range(0, 1)) begin
      add_char(".");
      gen_digits(1);
    end
    if ($urandom_range(0, 2) == 0) begin
      add_char($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: add_char("+");
        1: add_char("-");
        default: ;
      endcase
      gen_digits(1);
    end
  endfunction

  function automatic void gen_value(int lvl);
    int n;
    int pick;
    pick = (lvl >= 6) ? $urandom_range(2, 7) : $urandom_range(0, 7);
    add_ws();
    case (pick)
      0, 1: begin
        add_char(pick == 0 ? "[" : "{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) add_char(",");
          if (pick == 1) begin
            add_ws();
            gen_string();
            add_ws();
            add_char(":");
          end
          gen_value(lvl + 1);
        end
        add_ws();
        add_char(pick == 0 ? "]" : "}");
      end
      2: add_str("true");
      3: add_str("false");
      4: add_str("null");
      5, 6: gen_number();
      default: gen_string();
    endcase
    add_ws();
  endfunction

  task automatic test_open_top();
    add_str(" \t\r\n[");
    send_text();
  endtask

  task automatic test_literals_and_empty();
    add_str("{},[],true,false,null,{\"k\":[0]}");
    send_text();
  endtask

  task automatic test_numbers_and_finish();
    busy_mode = 1;
    add_str(",-0.5e+3,0E1,98");
    send_text();
    send_request(CMD_FINISH, 8'h00);
    add_str(",1.5");
    send_text();
    send_request(CMD_FINISH, 8'h00);
    add_str(",-");
    send_text();
    send_request(CMD_FINISH, 8'h00);
    add_str("7,");
    send_text();
    send_request(CMD_FINISH, 8'h00);
    busy_mode = 0;
  endtask

  task automatic test_string_escapes();
    add_str("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\uD83D\\uDE00\\udc00\\u00FF");
    add_char(8'hFF);
    add_str("\"");
    send_text();
    // Let every result drain before going on.
    wait (expected_events.size() == 0);
    repeat (5) @(negedge clk);
  endtask

  task automatic test_random_documents();
    int sent;
    sent = 0;
    while (sent < 1800) begin
      if ($urandom_range(0, 9) == 0) busy_mode = !busy_mode;
      add_char(",");
      gen_value(1);
      sent += text_q.size();
      send_text();
    end
    busy_mode = 0;
  endtask

  task automatic test_ending();
    case ($urandom_range(0, 2))
      0: add_str("] \n x{1");
      1: add_str(",] 1");
      default: repeat (MaxDepth) add_char("[");
    endcase
    send_text();
    send_request(CMD_FINISH, 8'h00);
    add_str("\n\"");
    send_text();
    inp.valid = 1'b0;
  endtask

  // Receiver stalls.
  int stall_left;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      outp.ready <= 1'b0;
    end else if (!stall_mode && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      outp.ready <= 1'b0;
    end else begin
      outp.ready <= 1'b1;
    end
    if ($urandom_range(0, 199) == 0) stall_mode <= !stall_mode;
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_rec_t x;
    if (!rst && outp.valid && outp.ready) begin
      if (expected_events.size() == 0) begin
        $error("event_res: expected nothing, actual %0d", outp.event_res);
        errors++;
      end else begin
        x = expected_events.pop_front();
        check_field("event_res", x.e.ev, outp.event_res);
        check_field("number_is_real", x.e.num_real, outp.number_is_real);
        check_field("in_key", x.e.key, outp.in_key);
        check_field("code_point", x.e.cp, outp.code_point);
        check_field("status", x.status, outp.status);
        check_field("line_number", x.line, outp.line_number);
        check_field("column_number", x.col, outp.column_number);
        check_field("last_of_run", x.last, outp.last_of_run);
      end
    end
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    errors = 0;
    busy_mode = 0;
    stall_mode = 0;
    stall_left = 0;
    outp.ready = 1'b0;
    inp.valid = 1'b0;
    inp.cmd = CMD_CHAR;
    inp.char_byte = 8'h00;
    pst = P_VALUE;
    kinds = '{default: 0};
    depth = 0;
    just_opened = 0;
    hi_unit = 0;
    lo_unit = 0;
    line_cnt = 0;
    col_cnt = 0;
    str_key = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_open_top();
    test_literals_and_empty();
    test_numbers_and_finish();
    test_string_escapes();
    test_random_documents();
    test_ending();
    wait (expected_events.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
